// ----- src/scrp_pkg.sv -----
// Shared types, codes and widths for the strip charge-ratio position block.
package scrp_pkg;

    // Number of strips on the plane; the hit counter saturates at this or at 255.
    localparam int STRIP_COUNT = 128;
    localparam logic [7:0] HIT_CAP = (STRIP_COUNT < 255) ? 8'(STRIP_COUNT) : 8'd255;

    // Datapath widths of the serial arithmetic.
    localparam int A_W    = 18;   // strip term A, signed
    localparam int SUM_W  = 17;   // charge sum
    localparam int ACC_W  = 58;   // product and dividend accumulator, signed
    localparam int NABS_W = 57;   // magnitude of the dividend
    localparam int DEN_W  = 30;   // divisor 6144 * sum
    localparam int POS_W  = 32;   // position and quotient
    localparam int CNT_W  = 6;

    localparam int MUL1_STEPS = SUM_W;
    localparam int MUL2_STEPS = 16;
    localparam int DIV_STEPS  = NABS_W;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_GAP  = 2'd2,
        STAT_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_CENTER = 2'd0,
        CFG_PITCH  = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_FLIP   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_PREP,
        ST_MUL2,
        ST_DSET,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

// ----- src/strip_charge_ratio_position_top.sv -----
// Top level of the two-strip charge-ratio position block.

// A hit is taken whenever busy is low. The hit that carries the
// end-of-event mark raises busy: an event that fails a check (fewer than two
// hits, top strips not adjacent, zero charge sum) holds busy only through the
// check state, a valid event also through the radix-2 shift-add multiplier (17 steps
// over the charge sum, 16 over the strip pitch) and the restoring divider
// (57 quotient bits). The result appears in the same cycle as busy falls and is
// marked by done for exactly one cycle; there is no way to hold it off, so
// the receiver must take every beat as it comes.
module strip_charge_ratio_position_top
    import scrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Hit channel
    input  logic               start,
    output logic               busy,
    input  logic [6:0]         strip_number,
    input  logic [15:0]        hit_charge,
    input  logic               end_of_event,
    // Configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // Result channel
    output logic               done,
    output logic signed [31:0] position_mm,
    output logic               processed,
    output logic [1:0]         status,
    output logic [6:0]         top_strip,
    output logic [6:0]         second_strip,
    output logic [7:0]         hit_count
);

    // Configuration registers
    logic signed [15:0] center_reg;
    logic [15:0]        pitch_reg;
    logic signed [23:0] offset_reg;
    logic               flip_reg;

    // Event ranking state
    logic [6:0]  best_strip_reg,    best_strip_next;
    logic [15:0] best_charge_reg,   best_charge_next;
    logic [6:0]  runner_strip_reg,  runner_strip_next;
    logic [15:0] runner_charge_reg, runner_charge_next;
    logic [7:0]  hits_seen_reg,     hits_seen_next;

    // Sequencer and serial arithmetic
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   mcand_reg;
    logic [SUM_W-1:0]          mplier_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic [POS_W-1:0]          quo_reg;
    logic                      neg_reg;

    // Result registers
    logic                done_reg;
    logic signed [31:0]  position_reg;
    logic                processed_reg;
    status_t             status_reg;
    logic [6:0]          top_reg;
    logic [6:0]          second_reg;
    logic [7:0]          count_reg;

    logic accept;
    logic emit_reject;
    logic emit_fin;
    logic cnt_zero;

    logic                    above;
    logic                    below;
    status_t                 check_status;
    logic [SUM_W-1:0]        sum_val;
    logic [15:0]             diff_val;
    logic signed [A_W-1:0]   a_val;
    logic signed [ACC_W-1:0] prod_term;
    logic signed [ACC_W-1:0] diff_term;
    logic signed [ACC_W-1:0] m_val;
    logic [DEN_W:0]          trial;
    logic                    trial_ge;
    logic [POS_W-1:0]        quo_final;
    logic [POS_W-1:0]        pos_raw;
    logic [POS_W-1:0]        pos_val;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cnt_zero  = (cnt_reg == '0);

    // ---------------- Ranking of the two strongest hits ----------------
    always_comb
    begin
        best_strip_next    = best_strip_reg;
        best_charge_next   = best_charge_reg;
        runner_strip_next  = runner_strip_reg;
        runner_charge_next = runner_charge_reg;
        hits_seen_next     = hits_seen_reg;
        if (accept)
        begin
            priority if (hits_seen_reg == 8'd0)
            begin
                best_strip_next  = strip_number;
                best_charge_next = hit_charge;
            end
            else if (hit_charge > best_charge_reg)
            begin
                runner_strip_next  = best_strip_reg;
                runner_charge_next = best_charge_reg;
                best_strip_next    = strip_number;
                best_charge_next   = hit_charge;
            end
            else if (hits_seen_reg == 8'd1 || hit_charge > runner_charge_reg)
            begin
                runner_strip_next  = strip_number;
                runner_charge_next = hit_charge;
            end
            else
            begin
                // A weaker hit leaves both places as they are.
                runner_strip_next  = runner_strip_reg;
                runner_charge_next = runner_charge_reg;
            end
            if (hits_seen_reg < HIT_CAP)
            begin
                hits_seen_next = hits_seen_reg + 8'd1;
            end
        end
        else if (emit_reject || emit_fin)
        begin
            best_strip_next    = '0;
            best_charge_next   = '0;
            runner_strip_next  = '0;
            runner_charge_next = '0;
            hits_seen_next     = '0;
        end
    end

    // ---------------- Event checks and operands ----------------
    always_comb
    begin
        above    = ({1'b0, runner_strip_reg} == {1'b0, best_strip_reg} + 8'd1);
        below    = ({1'b0, runner_strip_reg} + 8'd1 == {1'b0, best_strip_reg});
        sum_val  = {1'b0, best_charge_reg} + {1'b0, runner_charge_reg};
        diff_val = best_charge_reg - runner_charge_reg;
        priority if (hits_seen_reg < 8'd2)
        begin
            check_status = STAT_FEW;
        end
        else if (!above && !below)
        begin
            check_status = STAT_GAP;
        end
        else if (sum_val == '0)
        begin
            check_status = STAT_ZERO;
        end
        else
        begin
            check_status = STAT_OK;
        end
        // A = 256*s0 - centre +/- 128, the half-strip step towards the runner.
        a_val = $signed({3'b000, best_strip_reg, 8'h00})
              - $signed({{(A_W-16){center_reg[15]}}, center_reg})
              + (above ? $signed(A_W'(128)) : -$signed(A_W'(128)));

        // M = 24*A*S -/+ 512*(c0 - c1), with A*S already in the accumulator.
        prod_term = (acc_reg <<< 4) + (acc_reg <<< 3);
        diff_term = $signed({{(ACC_W-25){1'b0}}, diff_val, 9'h000});
        m_val     = above ? (prod_term - diff_term) : (prod_term + diff_term);

        trial    = {rem_reg, acc_reg[NABS_W-1]};
        trial_ge = (trial >= {1'b0, den_reg});

        // Floor division of a signed dividend, taken modulo 2^32.
        if (neg_reg)
        begin
            quo_final = (rem_reg != '0) ? ~quo_reg : (~quo_reg + POS_W'(1));
        end
        else
        begin
            quo_final = quo_reg;
        end
        pos_raw = quo_final - {{(POS_W-24){offset_reg[23]}}, offset_reg};
        pos_val = flip_reg ? (~pos_raw + POS_W'(1)) : pos_raw;
    end

    // ---------------- Sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && end_of_event)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (check_status == STAT_OK) ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_DSET;
                end
            end
            ST_DSET:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- Sequencer: outputs ----------------
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        emit_reject = (state_reg == ST_CHECK) && (check_status != STAT_OK);
        emit_fin    = (state_reg == ST_FIN);
    end

    // ---------------- Control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            done_reg          <= 1'b0;
            best_strip_reg    <= '0;
            best_charge_reg   <= '0;
            runner_strip_reg  <= '0;
            runner_charge_reg <= '0;
            hits_seen_reg     <= '0;
            center_reg        <= '0;
            pitch_reg         <= '0;
            offset_reg        <= '0;
            flip_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            done_reg          <= emit_reject || emit_fin;
            best_strip_reg    <= best_strip_next;
            best_charge_reg   <= best_charge_next;
            runner_strip_reg  <= runner_strip_next;
            runner_charge_reg <= runner_charge_next;
            hits_seen_reg     <= hits_seen_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_CENTER: center_reg <= cfg_data[15:0];
                    CFG_PITCH:  pitch_reg  <= cfg_data[15:0];
                    CFG_OFFSET: offset_reg <= cfg_data;
                    CFG_FLIP:   flip_reg   <= cfg_data[0];
                    default:    flip_reg   <= flip_reg;
                endcase
            end
        end
    end

    // ---------------- Serial datapath ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_CHECK:
            begin
                acc_reg    <= '0;
                mcand_reg  <= ACC_W'(a_val);
                mplier_reg <= sum_val;
                cnt_reg    <= CNT_W'(MUL1_STEPS - 1);
            end
            ST_MUL1, ST_MUL2:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - CNT_W'(1);
            end
            ST_PREP:
            begin
                mcand_reg  <= m_val;
                // The rounding half, 3072*S, seeds the second product.
                acc_reg    <= $signed({{(ACC_W-SUM_W-12){1'b0}}, sum_val, 12'h000})
                            - $signed({{(ACC_W-SUM_W-10){1'b0}}, sum_val, 10'h000});
                mplier_reg <= {{(SUM_W-16){1'b0}}, pitch_reg};
                cnt_reg    <= CNT_W'(MUL2_STEPS - 1);
            end
            ST_DSET:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                acc_reg <= acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
                den_reg <= DEN_W'({sum_val, 12'h000}) + DEN_W'({sum_val, 11'h000});
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            end
            ST_DIV:
            begin
                rem_reg <= trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], trial_ge};
                acc_reg <= acc_reg <<< 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase

        if (emit_reject || emit_fin)
        begin
            position_reg  <= emit_fin ? $signed(pos_val) : 32'sd0;
            processed_reg <= emit_fin;
            status_reg    <= emit_fin ? STAT_OK : check_status;
            top_reg       <= best_strip_reg;
            second_reg    <= (hits_seen_reg >= 8'd2) ? runner_strip_reg : 7'd0;
            count_reg     <= hits_seen_reg;
        end
    end

    assign done         = done_reg;
    assign position_mm  = position_reg;
    assign processed    = processed_reg;
    assign status       = status_reg;
    assign top_strip    = top_reg;
    assign second_strip = second_reg;
    assign hit_count    = count_reg;

    // ---------------- Assertions ----------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while the sequencer is still running");

    a_last_hit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && end_of_event) |=> busy)
        else $error("end of event did not start the evaluation");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !processed) |-> (position_mm == 32'sd0 && status != STAT_OK))
        else $error("rejected event carries a position or an ok status");

    a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hits_seen_reg <= HIT_CAP)
        else $error("hit counter ran past its cap");

endmodule
